// ===== design/rbch_pkg.sv =====
// Shared types, codes and constants for the ray versus box closest-hit block.
`timescale 1ns / 1ps
package rbch_pkg;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CAST = 1'b1;

  localparam logic CFG_BOX_COUNT = 1'b0;
  localparam logic CFG_FACE_TOL  = 1'b1;

  localparam logic [2:0] NRM_NONE  = 3'd0;
  localparam logic [2:0] NRM_POS_X = 3'd1;
  localparam logic [2:0] NRM_NEG_X = 3'd2;
  localparam logic [2:0] NRM_POS_Y = 3'd3;
  localparam logic [2:0] NRM_NEG_Y = 3'd4;
  localparam logic [2:0] NRM_POS_Z = 3'd5;
  localparam logic [2:0] NRM_NEG_Z = 3'd6;

  localparam logic [9:0] HITS_MAX = 10'd1023;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // numerator magnitude bits of (bound - origin) * 2^16
  localparam int DIV_NUM_W = 49;
  localparam logic [5:0] DIV_STEPS = 6'd49;

  typedef struct packed {
    logic               action;
    logic [5:0]         box_index;
    logic [15:0]        material_index;
    logic signed [31:0] lo_or_origin_x;
    logic signed [31:0] lo_or_origin_y;
    logic signed [31:0] lo_or_origin_z;
    logic signed [31:0] hi_or_direction_x;
    logic signed [31:0] hi_or_direction_y;
    logic signed [31:0] hi_or_direction_z;
    logic [9:0]         prior_hits;
    logic [30:0]        prior_distance;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         hit_count;
    logic               closer_found;
    logic [30:0]        hit_distance;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;
    logic signed [31:0] hit_point_z;
    logic [2:0]         normal_code;
    logic [15:0]        hit_material;
    logic [5:0]         hit_box;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic [15:0]        mat;
  } box_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_READ, ST_DIV, ST_DWAIT, ST_MERGE,
    ST_EVAL, ST_MUL, ST_PNT, ST_NRM, ST_NEXT, ST_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       load_ray;
    logic       mem_rd;
    logic       div_start;
    logic       div_store;
    logic       merge;
    logic       eval;
    logic       mul;
    logic       pnt;
    logic       nrm;
    logic       next_box;
    logic       emit;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic closer;
    logic out_free;
  } sts_t;

endpackage

// ===== design/rbch_div.sv =====
// Iterative signed divider, one quotient bit per cycle, saturated Q16.16 quotient.
`timescale 1ns / 1ps
module rbch_div
  import rbch_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [DIV_NUM_W-1:0] num,
  input  logic signed [31:0]          den,
  output logic                        done,
  output logic signed [31:0]          quo
);

  logic                 busy_r, busy_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] q_r, q_nxt;
  logic [31:0]          den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [32:0]          sh;
  logic [32:0]          diff;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    sh       = {rem_r, q_r[DIV_NUM_W-1]};
    diff     = sh - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_STEPS;
      rem_nxt  = '0;
      q_nxt    = num[DIV_NUM_W-1] ? 49'(-num) : 49'(num);
      den_nxt  = den[31] ? 32'(-den) : 32'(den);
      neg_nxt  = num[DIV_NUM_W-1] ^ den[31];
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        if (!diff[32]) begin
          rem_nxt = diff[31:0];
          q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = sh[31:0];
          q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd0);

  always_comb begin
    if (neg_r) begin
      if (q_r > 49'h0_8000_0000) quo = Q_MIN;
      else                       quo = 32'(-q_r[31:0]);
    end else begin
      if (q_r > 49'h0_7FFF_FFFF) quo = Q_MAX;
      else                       quo = $signed(q_r[31:0]);
    end
  end

endmodule

// ===== design/rbch_dp.sv =====
// Datapath: box table, ray registers, slab merge, hit selection and result register.
`timescale 1ns / 1ps
module rbch_dp
  import rbch_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  box_t mem [MAX_BOXES];
  box_t box_r;

  logic [6:0]  box_count_r;
  logic [15:0] tol_r;
  logic [CW-1:0] idx_r;

  logic signed [31:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic [9:0]  hits_r;
  logic [30:0] best_r;
  logic        found_r;
  logic [30:0] rd_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [2:0]  rn_r;
  logic [15:0] rm_r;
  logic [5:0]  rb_r;
  logic signed [31:0] qa_r, qb_r, tn_r, tf_r;
  logic        miss_r;
  logic signed [63:0] prx_r, pry_r, prz_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        ld_en;
  logic [12:0] ld_addr_w;
  logic [12:0] idx_w;
  logic [12:0] n_w;

  // slab selection
  logic signed [31:0] cur_o, cur_d, cur_lo, cur_hi, cur_b;
  logic signed [32:0] diff;
  logic signed [DIV_NUM_W-1:0] num;
  logic signed [31:0] quo;
  logic        div_done;
  logic signed [31:0] sa, sb;
  logic        ax_miss;

  logic        hit;
  logic signed [31:0] t_cand;
  logic        closer;
  logic signed [31:0] t_cur;
  logic [12:0] rb_w;

  logic signed [64:0] sumx, sumy, sumz;
  logic signed [31:0] satx, saty, satz;
  logic signed [33:0] px_w, py_w, pz_w;
  logic signed [33:0] tol_w;
  logic [2:0]  rn_nxt;

  assign ld_addr_w = {7'b0, in_data.box_index};
  assign ld_en = cmd.accept && in_valid && (in_data.action == ACT_LOAD)
                 && (ld_addr_w < 13'(MAX_BOXES));
  assign idx_w = 13'(idx_r);
  assign n_w   = ({6'b0, box_count_r} > 13'(MAX_BOXES)) ? 13'(MAX_BOXES)
                                                         : {6'b0, box_count_r};

  always_ff @(posedge clk) begin
    if (ld_en) begin
      mem[ld_addr_w[AW-1:0]] <= '{min_x: in_data.lo_or_origin_x,
                                  min_y: in_data.lo_or_origin_y,
                                  min_z: in_data.lo_or_origin_z,
                                  max_x: in_data.hi_or_direction_x,
                                  max_y: in_data.hi_or_direction_y,
                                  max_z: in_data.hi_or_direction_z,
                                  mat:   in_data.material_index};
    end
    if (cmd.mem_rd) begin
      box_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.sel[2:1])
      2'd0: begin
        cur_o = ox_r; cur_d = dx_r; cur_lo = box_r.min_x; cur_hi = box_r.max_x;
      end
      2'd1: begin
        cur_o = oy_r; cur_d = dy_r; cur_lo = box_r.min_y; cur_hi = box_r.max_y;
      end
      default: begin
        cur_o = oz_r; cur_d = dz_r; cur_lo = box_r.min_z; cur_hi = box_r.max_z;
      end
    endcase
    cur_b = cmd.sel[0] ? cur_hi : cur_lo;
    diff  = {cur_b[31], cur_b} - {cur_o[31], cur_o};
    num   = {diff, 16'b0};
  end

  rbch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (cur_d),
    .done  (div_done),
    .quo   (quo)
  );

  // zero direction: unbounded inside the slab, a miss outside it
  always_comb begin
    ax_miss = 1'b0;
    if (cur_d == 32'sd0) begin
      sa = Q_MIN;
      sb = Q_MAX;
      ax_miss = !((cur_lo <= cur_o) && (cur_o <= cur_hi));
    end else if (qa_r > qb_r) begin
      sa = qb_r;
      sb = qa_r;
    end else begin
      sa = qa_r;
      sb = qb_r;
    end
  end

  always_comb begin
    hit    = !miss_r && (!tn_r[31] || !tf_r[31]);
    t_cand = tn_r[31] ? tf_r : tn_r;
    closer = hit && ((hits_r == 10'd0) || ($signed({1'b0, best_r}) > t_cand));
    t_cur  = $signed({1'b0, rd_r});
    rb_w   = idx_w;
  end

  always_comb begin
    sumx = 65'(prx_r >>> 16) + 65'(ox_r);
    sumy = 65'(pry_r >>> 16) + 65'(oy_r);
    sumz = 65'(prz_r >>> 16) + 65'(oz_r);
    satx = (sumx > 65'(Q_MAX)) ? Q_MAX : (sumx < 65'(Q_MIN)) ? Q_MIN : sumx[31:0];
    saty = (sumy > 65'(Q_MAX)) ? Q_MAX : (sumy < 65'(Q_MIN)) ? Q_MIN : sumy[31:0];
    satz = (sumz > 65'(Q_MAX)) ? Q_MAX : (sumz < 65'(Q_MIN)) ? Q_MIN : sumz[31:0];
  end

  always_comb begin
    px_w  = 34'(px_r);
    py_w  = 34'(py_r);
    pz_w  = 34'(pz_r);
    tol_w = $signed({18'b0, tol_r});
    if      (px_w >= 34'(box_r.max_x) - tol_w) rn_nxt = NRM_POS_X;
    else if (px_w <= 34'(box_r.min_x) + tol_w) rn_nxt = NRM_NEG_X;
    else if (py_w >= 34'(box_r.max_y) - tol_w) rn_nxt = NRM_POS_Y;
    else if (py_w <= 34'(box_r.min_y) + tol_w) rn_nxt = NRM_NEG_Y;
    else if (pz_w >= 34'(box_r.max_z) - tol_w) rn_nxt = NRM_POS_Z;
    else if (pz_w <= 34'(box_r.min_z) + tol_w) rn_nxt = NRM_NEG_Z;
    else                                       rn_nxt = NRM_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r <= 7'd0;
      tol_r       <= 16'd1;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_COUNT: box_count_r <= cfg_data[6:0];
          CFG_FACE_TOL:  tol_r       <= cfg_data;
          default:       tol_r       <= tol_r;
        endcase
      end
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
      if (cmd.load_ray)      idx_r <= '0;
      else if (cmd.next_box) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ray) begin
      ox_r    <= in_data.lo_or_origin_x;
      oy_r    <= in_data.lo_or_origin_y;
      oz_r    <= in_data.lo_or_origin_z;
      dx_r    <= in_data.hi_or_direction_x;
      dy_r    <= in_data.hi_or_direction_y;
      dz_r    <= in_data.hi_or_direction_z;
      hits_r  <= in_data.prior_hits;
      best_r  <= in_data.prior_distance;
      found_r <= 1'b0;
      rd_r    <= '0;
      px_r    <= '0;
      py_r    <= '0;
      pz_r    <= '0;
      rn_r    <= NRM_NONE;
      rm_r    <= '0;
      rb_r    <= '0;
    end
    if (cmd.mem_rd) miss_r <= 1'b0;
    if (cmd.div_store) begin
      if (cmd.sel[0]) qb_r <= quo;
      else            qa_r <= quo;
    end
    if (cmd.merge) begin
      if (cmd.sel[2:1] == 2'd0) begin
        tn_r   <= sa;
        tf_r   <= sb;
        miss_r <= ax_miss;
      end else begin
        if (ax_miss || (tn_r > sb) || (sa > tf_r)) miss_r <= 1'b1;
        tn_r <= (sa > tn_r) ? sa : tn_r;
        tf_r <= (sb < tf_r) ? sb : tf_r;
      end
    end
    if (cmd.eval) begin
      if (hit && (hits_r != HITS_MAX)) hits_r <= hits_r + 10'd1;
      if (closer) begin
        best_r  <= t_cand[30:0];
        rd_r    <= t_cand[30:0];
        found_r <= 1'b1;
        rm_r    <= box_r.mat;
        rb_r    <= rb_w[5:0];
      end
    end
    if (cmd.mul) begin
      prx_r <= t_cur * dx_r;
      pry_r <= t_cur * dy_r;
      prz_r <= t_cur * dz_r;
    end
    if (cmd.pnt) begin
      px_r <= satx;
      py_r <= saty;
      pz_r <= satz;
    end
    if (cmd.nrm) rn_r <= rn_nxt;
    if (cmd.emit) begin
      out_data_r.hit_count    <= hits_r;
      out_data_r.closer_found <= found_r;
      out_data_r.hit_distance <= rd_r;
      out_data_r.hit_point_x  <= px_r;
      out_data_r.hit_point_y  <= py_r;
      out_data_r.hit_point_z  <= pz_r;
      out_data_r.normal_code  <= rn_r;
      out_data_r.hit_material <= rm_r;
      out_data_r.hit_box      <= rb_r;
    end
  end

  assign sts.last     = (idx_w >= n_w);
  assign sts.div_done = div_done;
  assign sts.closer   = closer;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/rbch_ctrl.sv =====
// Controller: sequences the box walk, the six slab divisions and the hit update.
`timescale 1ns / 1ps
module rbch_ctrl
  import rbch_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_action == ACT_CAST)) state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = sts.last ? ST_DONE : ST_READ;
      ST_READ: begin
        sel_nxt   = 3'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV:  state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (sts.div_done) begin
          if (sel_r[0]) begin
            state_nxt = ST_MERGE;
          end else begin
            sel_nxt   = sel_r + 3'd1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_MERGE: begin
        if (sel_r == 3'd5) begin
          state_nxt = ST_EVAL;
        end else begin
          sel_nxt   = sel_r + 3'd1;
          state_nxt = ST_DIV;
        end
      end
      ST_EVAL: state_nxt = sts.closer ? ST_MUL : ST_NEXT;
      ST_MUL:  state_nxt = ST_PNT;
      ST_PNT:  state_nxt = ST_NRM;
      ST_NRM:  state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = ST_CHECK;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel       = sel_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.accept   = 1'b1;
        cmd.load_ray = in_valid && (in_action == ACT_CAST);
      end
      ST_READ:  cmd.mem_rd    = 1'b1;
      ST_DIV:   cmd.div_start = 1'b1;
      ST_DWAIT: cmd.div_store = sts.div_done;
      ST_MERGE: cmd.merge     = 1'b1;
      ST_EVAL:  cmd.eval      = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_PNT:   cmd.pnt       = 1'b1;
      ST_NRM:   cmd.nrm       = 1'b1;
      ST_NEXT:  cmd.next_box  = 1'b1;
      ST_DONE:  cmd.emit      = sts.out_free;
      default:  cmd.sel       = sel_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// ===== design/ray_box_closest_hit.sv =====
// Top level of the ray versus box-table closest-hit unit.
//
// Input channel (in_valid/in_ready/in_data): a load item writes one box entry
// (min corner, max corner, material) and gives no result. A cast item tests
// one ray against the first box_count entries, at most MAX_BOXES of them,
// and gives exactly one result item on out_valid/out_ready/out_data.
// Configuration: cfg_we with cfg_index 0 sets box_count, index 1 sets the
// Q16.16 face tolerance. Write only while no cast is in flight.
// Sequencing: a cast walks the boxes one at a time. Each box takes one table
// read, six slab divisions on a shared divider that retires one quotient bit
// per cycle, three merge steps and an update, with multiply, hit point and
// normal steps added when the box becomes the new closest hit. Only one cast
// is worked on at a time.
// Reset: box_count clears to 0, the tolerance to 1, the output goes empty.
// The box table is not cleared; entries must be loaded before a cast reads them.
// Stall: the result sits in an output register until taken. A finished cast
// holds in its final state while that register is full; loads are not taken
// during a cast.
`timescale 1ns / 1ps
module ray_box_closest_hit
  import rbch_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: walk boxes, drive the datapath step by step
  rbch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, divider, merge and hit logic, plus the result register
  rbch_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ray versus box-table closest-hit unit.
`timescale 1ns / 1ps
module tb_top;
  import rbch_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int ONE = 65536;  // 1.0 in Q16.16

  // Scoreboard: mirrors the box table and the two registers, predicts one
  // result per cast and checks results in order of arrival.
  class hit_scoreboard;
    box_t       tbl[TBL_DEPTH];
    int         box_count;
    int         face_tol;
    int         errors;
    out_item_t  expected_q[$];

    function new();
      foreach (tbl[i]) tbl[i] = '0;
      box_count = 0;
      face_tol = 1;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void set_config(logic idx, int val);
      if (idx == CFG_BOX_COUNT) box_count = val & 'h7F;
      else face_tol = val & 'hFFFF;
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
    endfunction

    // One slab of the test: 0 on a miss, else entry and exit distances.
    function bit slab(longint lo, longint hi, longint o, longint d,
                      output longint tn, output longint tf);
      longint a, b, s;
      tn = 0;
      tf = 0;
      if (d == 0) begin
        if (lo <= o && o <= hi) begin
          tn = longint'(Q_MIN);
          tf = longint'(Q_MAX);
          return 1;
        end
        return 0;
      end
      a = clamp32(((lo - o) * 65536) / d);
      b = clamp32(((hi - o) * 65536) / d);
      if (a > b) begin
        s = a; a = b; b = s;
      end
      tn = a;
      tf = b;
      return 1;
    endfunction

    function out_item_t trace_ray(in_item_t it);
      longint ox, oy, oz, dx, dy, dz, best, tol;
      longint tn, tf, yn, yf, zn, zf, t, px, py, pz;
      int hits, n;
      out_item_t r;
      r = '0;
      ox = it.lo_or_origin_x; oy = it.lo_or_origin_y; oz = it.lo_or_origin_z;
      dx = it.hi_or_direction_x; dy = it.hi_or_direction_y; dz = it.hi_or_direction_z;
      hits = it.prior_hits;
      best = longint'(it.prior_distance);
      tol = face_tol;
      n = (box_count > TBL_DEPTH) ? TBL_DEPTH : box_count;
      for (int i = 0; i < n; i++) begin
        if (!slab(tbl[i].min_x, tbl[i].max_x, ox, dx, tn, tf)) continue;
        if (!slab(tbl[i].min_y, tbl[i].max_y, oy, dy, yn, yf)) continue;
        if (tn > yf || yn > tf) continue;
        if (yn > tn) tn = yn;
        if (yf < tf) tf = yf;
        if (!slab(tbl[i].min_z, tbl[i].max_z, oz, dz, zn, zf)) continue;
        if (tn > zf || zn > tf) continue;
        if (zn > tn) tn = zn;
        if (zf < tf) tf = zf;
        t = tn;
        if (t < 0) begin
          t = tf;
          if (t < 0) continue;
        end
        if (hits == 0 || best > t) begin
          best = t;
          px = clamp32(ox + ((t * dx) >>> 16));
          py = clamp32(oy + ((t * dy) >>> 16));
          pz = clamp32(oz + ((t * dz) >>> 16));
          r.closer_found = 1'b1;
          r.hit_distance = t[30:0];
          r.hit_point_x = px[31:0];
          r.hit_point_y = py[31:0];
          r.hit_point_z = pz[31:0];
          if (px >= longint'(tbl[i].max_x) - tol) r.normal_code = NRM_POS_X;
          else if (px <= longint'(tbl[i].min_x) + tol) r.normal_code = NRM_NEG_X;
          else if (py >= longint'(tbl[i].max_y) - tol) r.normal_code = NRM_POS_Y;
          else if (py <= longint'(tbl[i].min_y) + tol) r.normal_code = NRM_NEG_Y;
          else if (pz >= longint'(tbl[i].max_z) - tol) r.normal_code = NRM_POS_Z;
          else if (pz <= longint'(tbl[i].min_z) + tol) r.normal_code = NRM_NEG_Z;
          else r.normal_code = NRM_NONE;
          r.hit_material = tbl[i].mat;
          r.hit_box = i[5:0];
        end
        if (hits < int'(HITS_MAX)) hits++;
      end
      r.hit_count = hits[9:0];
      return r;
    endfunction

    function void note_input(in_item_t it);
      if (it.action == ACT_LOAD) begin
        tbl[it.box_index].min_x = it.lo_or_origin_x;
        tbl[it.box_index].min_y = it.lo_or_origin_y;
        tbl[it.box_index].min_z = it.lo_or_origin_z;
        tbl[it.box_index].max_x = it.hi_or_direction_x;
        tbl[it.box_index].max_y = it.hi_or_direction_y;
        tbl[it.box_index].max_z = it.hi_or_direction_z;
        tbl[it.box_index].mat = it.material_index;
      end else begin
        expected_q.push_back(trace_ray(it));
      end
    endfunction

    task cmp(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("result with no cast waiting");
        return;
      end
      want = expected_q.pop_front();
      cmp("hit_count", got.hit_count, want.hit_count);
      cmp("closer_found", got.closer_found, want.closer_found);
      cmp("hit_distance", got.hit_distance, want.hit_distance);
      cmp("hit_point_x", got.hit_point_x, want.hit_point_x);
      cmp("hit_point_y", got.hit_point_y, want.hit_point_y);
      cmp("hit_point_z", got.hit_point_z, want.hit_point_z);
      cmp("normal_code", got.normal_code, want.normal_code);
      cmp("hit_material", got.hit_material, want.hit_material);
      cmp("hit_box", got.hit_box, want.hit_box);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  hit_scoreboard sb = new();

  bit quiet;          // no idling on either side while set, but for a requested hold-off
  bit long_hold_req;  // ask the receiver for one long hold-off
  int hold_cnt;
  int stall_cnt;

  always #6 clk = ~clk;

  ray_box_closest_hit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver: random stalls, mostly short, a few long; one long hold-off on
  // request so results back up and the input side stalls.
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_cnt = 3000;
      long_hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) stall_cnt = $urandom_range(20, 60);
      else if (r < 12) stall_cnt = $urandom_range(0, 3);
      out_ready <= (r >= 12);
    end
  end

  // Check every result taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, idling first; hold valid high and the payload steady
  // until the item is taken.
  task send(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Drop valid and wait until every cast has delivered its result.
  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_cfg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    sb.set_config(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function in_item_t load_item(int idx, int mnx, int mny, int mnz,
                               int mxx, int mxy, int mxz, int mat);
    in_item_t it;
    it = '0;
    it.action = ACT_LOAD;
    it.box_index = idx[5:0];
    it.material_index = mat[15:0];
    it.lo_or_origin_x = mnx; it.lo_or_origin_y = mny; it.lo_or_origin_z = mnz;
    it.hi_or_direction_x = mxx; it.hi_or_direction_y = mxy; it.hi_or_direction_z = mxz;
    it.prior_hits = $urandom;
    it.prior_distance = $urandom;
    return it;
  endfunction

  function in_item_t cast_item(int ox, int oy, int oz, int dx, int dy, int dz,
                               int hits, int prior_dist);
    in_item_t it;
    it = '0;
    it.action = ACT_CAST;
    it.box_index = $urandom;
    it.material_index = $urandom;
    it.lo_or_origin_x = ox; it.lo_or_origin_y = oy; it.lo_or_origin_z = oz;
    it.hi_or_direction_x = dx; it.hi_or_direction_y = dy; it.hi_or_direction_z = dz;
    it.prior_hits = hits[9:0];
    it.prior_distance = prior_dist[30:0];
    return it;
  endfunction

  // Well-formed box: center within +-100.0, half sizes 0.5 .. 20.0.
  function in_item_t rand_box_load(int idx);
    int c[3], h[3];
    for (int a = 0; a < 3; a++) begin
      c[a] = int'($urandom_range(0, 200 * ONE)) - 100 * ONE;
      h[a] = $urandom_range(ONE / 2, 20 * ONE);
    end
    return load_item(idx, c[0] - h[0], c[1] - h[1], c[2] - h[2],
                     c[0] + h[0], c[1] + h[1], c[2] + h[2], $urandom);
  endfunction

  // Aim a ray at the center of a tested box, with jitter, a random scale and
  // now and then an axis-parallel component.
  function in_item_t aimed_cast();
    int n, k, s, hits, prior_dist;
    int o[3], d[3], tgt[3];
    box_t b;
    n = (sb.box_count > TBL_DEPTH) ? TBL_DEPTH : sb.box_count;
    k = (n == 0) ? $urandom_range(0, TBL_DEPTH - 1) : $urandom_range(0, n - 1);
    b = sb.tbl[k];
    tgt[0] = int'((longint'(b.min_x) + longint'(b.max_x)) >>> 1);
    tgt[1] = int'((longint'(b.min_y) + longint'(b.max_y)) >>> 1);
    tgt[2] = int'((longint'(b.min_z) + longint'(b.max_z)) >>> 1);
    s = $urandom_range(0, 4);
    for (int a = 0; a < 3; a++) begin
      tgt[a] += int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
      o[a] = int'($urandom_range(0, 400 * ONE)) - 200 * ONE;
      d[a] = (tgt[a] - o[a]) >>> s;
      if ($urandom_range(0, 7) == 0) begin
        d[a] = 0;
        o[a] = tgt[a];
      end
    end
    hits = ($urandom_range(0, 1) == 0) ? 0 :
           ($urandom_range(0, 9) == 0) ? int'(HITS_MAX) : $urandom_range(1, 20);
    prior_dist = $urandom_range(0, 300 * ONE);
    return cast_item(o[0], o[1], o[2], d[0], d[1], d[2], hits, prior_dist);
  endfunction

  function in_item_t noise_item();
    in_item_t it;
    it.action = $urandom;
    it.box_index = $urandom;
    it.material_index = $urandom;
    it.lo_or_origin_x = $urandom; it.lo_or_origin_y = $urandom;
    it.lo_or_origin_z = $urandom;
    it.hi_or_direction_x = $urandom; it.hi_or_direction_y = $urandom;
    it.hi_or_direction_z = $urandom;
    it.prior_hits = $urandom;
    it.prior_distance = $urandom;
    return it;
  endfunction

  // One random phase at one register setting; casts_only keeps slow settings
  // to casts.
  task run_phase(int bc, int tol, int items, bit no_idle, bit hold_off, bit casts_only);
    int r;
    drain();
    write_cfg(CFG_BOX_COUNT, bc);
    write_cfg(CFG_FACE_TOL, tol);
    quiet = no_idle;
    if (hold_off) long_hold_req = 1;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (casts_only) send(aimed_cast());
      else if (r < 12) send(noise_item());
      else if (r < 45) send(rand_box_load($urandom_range(0, TBL_DEPTH - 1)));
      else send(aimed_cast());
    end
    quiet = 0;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BOX_COUNT;
    cfg_data = '0;
    quiet = 0;
    long_hold_req = 0;
    hold_cnt = 0;
    stall_cnt = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a small table, then rays on each special case.
    send(load_item(0, ONE, ONE, ONE, 3 * ONE, 3 * ONE, 3 * ONE, 'hFFFF));
    send(load_item(1, ONE, ONE, ONE, 3 * ONE, 3 * ONE, 3 * ONE, 'h0001));  // tie
    send(load_item(2, -10 * ONE, -10 * ONE, -10 * ONE, -8 * ONE, -8 * ONE, -8 * ONE,
                   'h1234));
    send(load_item(3, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0));  // whole space
    send(load_item(63, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 'hFFFF));
    drain();
    send(cast_item(0, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, 0));  // table empty of tests
    drain();
    write_cfg(CFG_BOX_COUNT, 4);
    send(cast_item(0, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, 0));       // zero dir inside
    send(cast_item(0, 5 * ONE, 2 * ONE, ONE, 0, 0, 0, 0));       // zero dir outside
    send(cast_item(2 * ONE, 2 * ONE, 2 * ONE, 0, 0, ONE, 0, 0)); // origin inside box
    send(cast_item(20 * ONE, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, 0));// boxes behind
    send(cast_item(0, 2 * ONE, 2 * ONE, ONE, 0, 0, HITS_MAX, 0));  // saturate count
    send(cast_item(0, 2 * ONE, 2 * ONE, ONE, 0, 0, 5, 'h7FFFFFFF));
    send(cast_item(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0, 0));
    send(cast_item(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1, 0));
    send(cast_item(0, 0, 0, 0, 0, 0, 0, 0));
    send(cast_item(-20 * ONE, -20 * ONE, -20 * ONE, ONE, ONE, ONE, 0, 0));

    // Fill the whole table before any cast can reach past entry 3.
    drain();
    quiet = 1;
    for (int i = 0; i < TBL_DEPTH; i++) send(rand_box_load(i));
    quiet = 0;

    run_phase(1, 1, 120, 1, 1, 0);  // long receiver hold-off, sender keeps going
    run_phase(2, 0, 120, 0, 0, 0);
    run_phase(3, 'hFFFF, 120, 0, 0, 0);
    run_phase(4, $urandom_range(0, 'hFFFF), 120, 0, 0, 0);
    run_phase(0, $urandom_range(0, 4 * ONE), 60, 0, 0, 0);
    run_phase(6, ONE, 100, 0, 0, 0);
    run_phase(64, $urandom_range(0, 'hFFFF), 4, 0, 0, 1);
    run_phase(127, 2 * ONE, 3, 0, 0, 1);  // above the table size
    run_phase(2, $urandom_range(0, 'hFFFF), 120, 1, 0, 0);
    run_phase(1, $urandom_range(0, 'hFFFF), 120, 0, 0, 0);

    // Wait out the last results, with a limit.
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.expected_q.size() != 0) $display("%0d results never came", sb.expected_q.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #480_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
